### rtl/aedt_pkg.sv
// ----------------------------------------------------------------------------
// aedt_pkg - shared types and constants for the extreme direction tracker
// Field widths, divider sizing, direction tables and the multiplier tag.
// ----------------------------------------------------------------------------
package aedt_pkg;

    // Field and stream widths
    localparam int COORD_W      = 32;
    localparam int NUM_AXES     = 3;
    localparam int NUM_DIR      = 6;
    localparam int DIR_W        = 3;
    localparam int MASK_W       = NUM_DIR;
    localparam int IN_TDATA_W   = 9 * COORD_W;
    localparam int OUT_FIELDS_W = MASK_W + 6 * COORD_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    // Sum of three coordinates and its divide-by-three
    localparam int SUM_W         = COORD_W + 2;
    localparam int DIV_DIGITS    = 3;
    localparam int DIV_STEP_BITS = 2 * DIV_DIGITS;
    localparam int DIV_STEPS     = 6;
    localparam int DIV_W         = DIV_STEPS * DIV_STEP_BITS;
    localparam int DIV_CNT_W     = 3;

    // Squares, norms and the cross-product accumulator
    localparam int HALF_W = COORD_W;
    localparam int SQ_W   = 2 * COORD_W;
    localparam int NORM_W = 2 * COORD_W;
    localparam int PROD_W = 2 * HALF_W;
    localparam int ACC_W  = 2 * NORM_W + 2;

    // Saturation bounds of an offset
    localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_Z = 2'd2;

    // Axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Direction codes, in mask bit order
    localparam logic [DIR_W-1:0] DIR_POS_X = 3'd0;
    localparam logic [DIR_W-1:0] DIR_NEG_X = 3'd1;
    localparam logic [DIR_W-1:0] DIR_NEG_Z = 3'd2;
    localparam logic [DIR_W-1:0] DIR_POS_Z = 3'd3;
    localparam logic [DIR_W-1:0] DIR_POS_Y = 3'd4;
    localparam logic [DIR_W-1:0] DIR_NEG_Y = 3'd5;

    // Partial product placement, in 32-bit words
    localparam logic [1:0] SHIFT_W0 = 2'd0;
    localparam logic [1:0] SHIFT_W1 = 2'd1;
    localparam logic [1:0] SHIFT_W2 = 2'd2;

    // Routing of a product leaving the shared multiplier
    typedef struct packed {
        logic       acc_en;
        logic       sq_en;
        logic [1:0] sq_idx;
        logic [1:0] shift;
        logic       sub;
    } mul_tag_t;

    function automatic logic [1:0] dir_axis(input logic [DIR_W-1:0] dir);
        logic [1:0] axis;
        case (dir)
            DIR_POS_X, DIR_NEG_X: axis = AXIS_X;
            DIR_NEG_Z, DIR_POS_Z: axis = AXIS_Z;
            DIR_POS_Y, DIR_NEG_Y: axis = AXIS_Y;
            default:              axis = AXIS_X;
        endcase
        return axis;
    endfunction

    function automatic logic dir_negated(input logic [DIR_W-1:0] dir);
        logic neg;
        case (dir)
            DIR_NEG_X, DIR_NEG_Z, DIR_NEG_Y: neg = 1'b1;
            default:                         neg = 1'b0;
        endcase
        return neg;
    endfunction

endpackage

### rtl/aedt_div3.sv
// ----------------------------------------------------------------------------
// aedt_div3 - iterative signed divide by three
// Radix-4 digit recurrence, several digits per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module aedt_div3 import aedt_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [SUM_W-1:0]   dividend,
    output logic                      done,
    output logic signed [COORD_W-1:0] quotient
);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic                     neg_reg, neg_next;
    logic [DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_W-1:0]         work_reg, work_next;
    logic [1:0]               rem_reg, rem_next;
    logic [SUM_W-1:0]         dividend_mag;
    logic [1:0]               rem_chain [DIV_DIGITS+1];
    logic [3:0]               digit_res [DIV_DIGITS];
    logic [DIV_STEP_BITS-1:0] qbits;
    logic [COORD_W-1:0]       quot_mag;

    // Returns {quotient digit, remainder} of a 4-bit partial dividend
    function automatic logic [3:0] div3_digit(input logic [3:0] r4);
        logic [1:0] q;
        logic [3:0] rem4;
        if (r4 >= 4'd9) begin
            q = 2'd3;
        end else if (r4 >= 4'd6) begin
            q = 2'd2;
        end else if (r4 >= 4'd3) begin
            q = 2'd1;
        end else begin
            q = 2'd0;
        end
        rem4 = r4 - {1'b0, q, 1'b0} - {2'b00, q};
        return {q, rem4[1:0]};
    endfunction

    assign dividend_mag = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;

    always_comb begin
        rem_chain[0] = rem_reg;
        qbits        = '0;
        for (int d = 0; d < DIV_DIGITS; d++) begin
            digit_res[d]     = div3_digit({rem_chain[d], work_reg[DIV_W-1-2*d -: 2]});
            rem_chain[d+1]   = digit_res[d][1:0];
            qbits[DIV_STEP_BITS-1-2*d -: 2] = digit_res[d][3:2];
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            neg_next  = dividend[SUM_W-1];
            work_next = DIV_W'(dividend_mag);
        end else if (busy_reg) begin
            // shift out the consumed dividend bits, shift in quotient bits
            work_next = {work_reg[DIV_W-DIV_STEP_BITS-1:0], qbits};
            rem_next  = rem_chain[DIV_DIGITS];
            cnt_next  = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        neg_reg  <= neg_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign quot_mag = work_reg[COORD_W-1:0];
    assign quotient = neg_reg ? signed'(~quot_mag + COORD_W'(1)) : signed'(quot_mag);
    assign done     = done_reg;

endmodule

### rtl/aedt_mul.sv
// ----------------------------------------------------------------------------
// aedt_mul - shared 32x32 unsigned multiplier
// Registered product; the routing tag travels alongside with the same delay.
// ----------------------------------------------------------------------------
module aedt_mul import aedt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [HALF_W-1:0] op_a,
    input  logic [HALF_W-1:0] op_b,
    input  mul_tag_t          tag_in,
    output logic [PROD_W-1:0] product,
    output mul_tag_t          tag_out
);

    logic [PROD_W-1:0] product_reg, product_next;
    mul_tag_t          tag_reg, tag_next;

    assign product_next = PROD_W'(op_a) * PROD_W'(op_b);
    assign tag_next     = tag_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else begin
            tag_reg <= tag_next;
        end
        product_reg <= product_next;
    end

    assign product = product_reg;
    assign tag_out = tag_reg;

endmodule

### rtl/axis_extreme_direction_tracker.sv
// ----------------------------------------------------------------------------
// axis_extreme_direction_tracker - per-axis extreme face tracker
// Centroid, offset from model center and exact cosine ranking per direction.
// ----------------------------------------------------------------------------
// Each input word carries one triangle (three vertices, signed Q16.16). The
// block returns one output word per triangle: the centroid, its offset from
// the configured model center (saturated to 32 bits) and a mask of the six
// directions (+x, -x, -z, +z, +y, -y) whose best-aligned face this triangle
// became. A triangle keeps the block busy from its acceptance until its result
// is handed over, and no new triangle is taken meanwhile. In order, the block
// launches the dividers, runs the divide-by-three of the centroid (six
// recurrence steps and the done cycle), forms the saturated offsets, squares
// the offsets and sums them, runs the direction pass, in which one shared
// 32x32 multiplier builds two 128-bit cross products per direction from eight
// partial products, and hands the result to the output register. That last
// step stalls while an earlier result still waits on m_axis_tready. Write
// center registers only while no triangle is in flight. Reset clears the
// direction history so that the next face wins every direction it is not
// pointing exactly away from.
module axis_extreme_direction_tracker import aedt_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
    // vertex_c_x, vertex_c_y, vertex_c_z (32 bits each, from bit 0 up)
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // updated_mask (6), centroid_x, centroid_y, centroid_z, offset_x,
    // offset_y, offset_z (32 each), two zero pad bits on top
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // center register writes: 0 = center_x, 1 = center_y, 2 = center_z
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]     cfg_data
);

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;   // wait for a triangle
    localparam logic [3:0] S_DIVS = 4'd1;   // launch the three dividers
    localparam logic [3:0] S_DIVW = 4'd2;   // wait for the centroid
    localparam logic [3:0] S_OFF  = 4'd3;   // offset and saturation
    localparam logic [3:0] S_SQ   = 4'd4;   // square the three offsets
    localparam logic [3:0] S_SQW  = 4'd5;   // drain the last square
    localparam logic [3:0] S_NORM = 4'd6;   // sum of squares
    localparam logic [3:0] S_DIR  = 4'd7;   // per-direction compare
    localparam logic [3:0] S_OUT  = 4'd8;   // hand over the result word

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_DECIDE = 4'd9;

    // Control
    logic [3:0]        state_reg, state_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [DIR_W-1:0]  dir_reg, dir_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;
    logic [NUM_DIR-1:0] found_reg, found_next;

    // Configuration
    logic signed [COORD_W-1:0] center_reg [NUM_AXES];
    logic signed [COORD_W-1:0] center_next [NUM_AXES];

    // Per-triangle datapath
    logic signed [SUM_W-1:0]   sum_reg [NUM_AXES];
    logic signed [SUM_W-1:0]   sum_next [NUM_AXES];
    logic signed [COORD_W-1:0] cen_reg [NUM_AXES];
    logic signed [COORD_W-1:0] cen_next [NUM_AXES];
    logic signed [COORD_W-1:0] off_reg [NUM_AXES];
    logic signed [COORD_W-1:0] off_next [NUM_AXES];
    logic [SQ_W-1:0]           sq_reg [NUM_AXES];
    logic [SQ_W-1:0]           sq_next [NUM_AXES];
    logic [NORM_W-1:0]         norm_reg, norm_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [NUM_DIR-1:0]        mask_reg, mask_next;
    logic [OUT_TDATA_W-1:0]    out_data_reg, out_data_next;

    // Direction history
    logic signed [COORD_W-1:0] best_comp_reg [NUM_DIR];
    logic signed [COORD_W-1:0] best_comp_next [NUM_DIR];
    logic [NORM_W-1:0]         best_norm_reg [NUM_DIR];
    logic [NORM_W-1:0]         best_norm_next [NUM_DIR];
    logic [SQ_W-1:0]           best_sq_reg [NUM_DIR];
    logic [SQ_W-1:0]           best_sq_next [NUM_DIR];

    // Combinational helpers
    logic                      in_fire;
    logic                      out_load;
    logic signed [SUM_W-1:0]   vertex_sum [NUM_AXES];
    logic                      div_start;
    logic [NUM_AXES-1:0]       div_done;
    logic signed [COORD_W-1:0] div_quot [NUM_AXES];
    logic signed [COORD_W:0]   diff [NUM_AXES];
    logic [COORD_W-1:0]        sat_off [NUM_AXES];

    logic [HALF_W-1:0]  mul_a, mul_b;
    mul_tag_t           mul_tag_in, mul_tag_out;
    logic [PROD_W-1:0]  mul_product;
    logic [SQ_W-1:0]    first_op;
    logic [NORM_W-1:0]  second_op;
    logic signed [ACC_W-1:0] acc_term;

    logic [1:0]                dec_axis;
    logic                      dec_neg;
    logic signed [COORD_W-1:0] coord;
    logic signed [COORD_W-1:0] kept;
    logic                      c_pos, c_neg, k_pos, k_neg;
    logic                      a_pos, a_neg, b_pos, b_neg;
    logic                      acc_pos, acc_neg;
    logic                      take;

    function automatic logic [COORD_W-1:0] mag32(input logic [COORD_W-1:0] v);
        return v[COORD_W-1] ? (~v + COORD_W'(1)) : v;
    endfunction

    function automatic logic signed [SUM_W-1:0] sext_sum(input logic [COORD_W-1:0] v);
        return signed'({{(SUM_W-COORD_W){v[COORD_W-1]}}, v});
    endfunction

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_load      = (state_reg == S_OUT) && (!m_valid_reg || m_axis_tready);
    assign div_start     = (state_reg == S_DIVS);

    // Per-axis sum of the three vertices, then the divide-by-three lanes
    for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
        assign vertex_sum[k] = sext_sum(s_axis_tdata[k*COORD_W +: COORD_W])
                             + sext_sum(s_axis_tdata[(NUM_AXES+k)*COORD_W +: COORD_W])
                             + sext_sum(s_axis_tdata[(2*NUM_AXES+k)*COORD_W +: COORD_W]);

        aedt_div3 u_div3 (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (div_start),
            .dividend (sum_reg[k]),
            .done     (div_done[k]),
            .quotient (div_quot[k])
        );

        // centroid minus center, clamped to the 32-bit range
        assign diff[k] = {div_quot[k][COORD_W-1], div_quot[k]}
                       - {center_reg[k][COORD_W-1], center_reg[k]};
        assign sat_off[k] = (diff[k][COORD_W] != diff[k][COORD_W-1])
                          ? (diff[k][COORD_W] ? SAT_MIN : SAT_MAX)
                          : diff[k][COORD_W-1:0];
    end

    // Operand selection for the shared multiplier
    always_comb begin
        mul_a      = '0;
        mul_b      = '0;
        mul_tag_in = '0;
        first_op   = step_reg[2] ? best_sq_reg[dir_reg] : sq_reg[dir_axis(dir_reg)];
        second_op  = step_reg[2] ? norm_reg : best_norm_reg[dir_reg];
        case (state_reg)
            S_SQ: begin
                mul_a             = mag32(off_reg[cnt_reg]);
                mul_b             = mag32(off_reg[cnt_reg]);
                mul_tag_in.sq_en  = 1'b1;
                mul_tag_in.sq_idx = cnt_reg;
            end
            S_DIR: begin
                // steps 0-3 build a^2 * m, steps 4-7 subtract b^2 * n
                if (!step_reg[3]) begin
                    mul_a             = step_reg[1] ? first_op[SQ_W-1:HALF_W]
                                                    : first_op[HALF_W-1:0];
                    mul_b             = step_reg[0] ? second_op[NORM_W-1:HALF_W]
                                                    : second_op[HALF_W-1:0];
                    mul_tag_in.acc_en = found_reg[dir_reg];
                    mul_tag_in.sub    = step_reg[2];
                    mul_tag_in.shift  = (step_reg[1] && step_reg[0]) ? SHIFT_W2
                                      : (step_reg[1] ^ step_reg[0]) ? SHIFT_W1 : SHIFT_W0;
                end
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    aedt_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .tag_in  (mul_tag_in),
        .product (mul_product),
        .tag_out (mul_tag_out)
    );

    // Place a partial product at its word offset in the accumulator
    always_comb begin
        case (mul_tag_out.shift)
            SHIFT_W0: acc_term = signed'(ACC_W'(mul_product));
            SHIFT_W1: acc_term = signed'(ACC_W'({mul_product, {HALF_W{1'b0}}}));
            SHIFT_W2: acc_term = signed'(ACC_W'({mul_product, {(2*HALF_W){1'b0}}}));
            default:  acc_term = '0;
        endcase
    end

    // Decision for the current direction, from signs first, then the
    // sign of a^2 * m - b^2 * n held in the accumulator
    always_comb begin
        dec_axis = dir_axis(dir_reg);
        dec_neg  = dir_negated(dir_reg);
        coord    = off_reg[dec_axis];
        kept     = best_comp_reg[dir_reg];
        c_pos    = !coord[COORD_W-1] && (coord != '0);
        c_neg    = coord[COORD_W-1];
        k_pos    = !kept[COORD_W-1] && (kept != '0);
        k_neg    = kept[COORD_W-1];
        a_pos    = dec_neg ? c_neg : c_pos;
        a_neg    = dec_neg ? c_pos : c_neg;
        b_pos    = dec_neg ? k_neg : k_pos;
        b_neg    = dec_neg ? k_pos : k_neg;
        acc_neg  = acc_reg[ACC_W-1];
        acc_pos  = !acc_reg[ACC_W-1] && (acc_reg != '0);
        if (!found_reg[dir_reg]) begin
            // an empty direction refuses only a face pointing straight away
            take = !(a_neg && (sq_reg[dec_axis] == norm_reg));
        end else begin
            take = (a_pos && !b_pos) || (!a_neg && b_neg)
                || (a_pos && b_pos && acc_pos) || (a_neg && b_neg && acc_neg);
        end
    end

    // Sequencer and datapath next state
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        dir_next       = dir_reg;
        step_next      = step_reg;
        found_next     = found_reg;
        center_next    = center_reg;
        sum_next       = sum_reg;
        cen_next       = cen_reg;
        off_next       = off_reg;
        sq_next        = sq_reg;
        norm_next      = norm_reg;
        acc_next       = acc_reg;
        mask_next      = mask_reg;
        out_data_next  = out_data_reg;
        best_comp_next = best_comp_reg;
        best_norm_next = best_norm_reg;
        best_sq_next   = best_sq_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;

        // center writes; indexes past center_z are dropped
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_CENTER_X: center_next[AXIS_X] = signed'(cfg_data);
                CFG_CENTER_Y: center_next[AXIS_Y] = signed'(cfg_data);
                CFG_CENTER_Z: center_next[AXIS_Z] = signed'(cfg_data);
                default:      center_next[AXIS_X] = center_reg[AXIS_X];
            endcase
        end

        // products leaving the multiplier
        if (mul_tag_out.sq_en) begin
            sq_next[mul_tag_out.sq_idx] = mul_product;
        end
        if (mul_tag_out.acc_en) begin
            acc_next = mul_tag_out.sub ? (acc_reg - acc_term) : (acc_reg + acc_term);
        end

        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    sum_next   = vertex_sum;
                    mask_next  = '0;
                    state_next = S_DIVS;
                end
            end
            S_DIVS: begin
                state_next = S_DIVW;
            end
            S_DIVW: begin
                if (&div_done) begin
                    state_next = S_OFF;
                end
            end
            S_OFF: begin
                for (int k = 0; k < NUM_AXES; k++) begin
                    cen_next[k] = div_quot[k];
                    off_next[k] = signed'(sat_off[k]);
                end
                cnt_next   = '0;
                state_next = S_SQ;
            end
            S_SQ: begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'(NUM_AXES - 1)) begin
                    state_next = S_SQW;
                end
            end
            S_SQW: begin
                state_next = S_NORM;
            end
            S_NORM: begin
                norm_next  = sq_reg[AXIS_X] + sq_reg[AXIS_Y] + sq_reg[AXIS_Z];
                dir_next   = '0;
                step_next  = '0;
                state_next = S_DIR;
            end
            S_DIR: begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == '0) begin
                    acc_next = '0;
                end
                if (step_reg == STEP_DECIDE) begin
                    if (take) begin
                        best_comp_next[dir_reg] = coord;
                        best_norm_next[dir_reg] = norm_reg;
                        best_sq_next[dir_reg]   = sq_reg[dec_axis];
                        found_next[dir_reg]     = 1'b1;
                        mask_next[dir_reg]      = 1'b1;
                    end
                    step_next = '0;
                    if (dir_reg == DIR_W'(NUM_DIR - 1)) begin
                        state_next = S_OUT;
                    end else begin
                        dir_next = dir_reg + DIR_W'(1);
                    end
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (out_load) begin
                    out_data_next = {{OUT_PAD_W{1'b0}},
                                     off_reg[AXIS_Z], off_reg[AXIS_Y], off_reg[AXIS_X],
                                     cen_reg[AXIS_Z], cen_reg[AXIS_Y], cen_reg[AXIS_X],
                                     mask_reg};
                    m_valid_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            dir_reg     <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
            found_reg   <= '0;
            for (int k = 0; k < NUM_AXES; k++) begin
                center_reg[k] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            dir_reg     <= dir_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
            found_reg   <= found_next;
            center_reg  <= center_next;
        end
        sum_reg       <= sum_next;
        cen_reg       <= cen_next;
        off_reg       <= off_next;
        sq_reg        <= sq_next;
        norm_reg      <= norm_next;
        acc_reg       <= acc_next;
        mask_reg      <= mask_next;
        out_data_reg  <= out_data_next;
        best_comp_reg <= best_comp_next;
        best_norm_reg <= best_norm_next;
        best_sq_reg   <= best_sq_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

### dv/axis_extreme_direction_tracker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// axis_extreme_direction_tracker_tb - self-checking bench for the face tracker
// Streams triangles through the block under random stalls on both sides.
// Each accepted triangle is ranked by an in-bench model of the centroid,
// saturated offset and exact per-direction cosine ranking. Every output word
// is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module axis_extreme_direction_tracker_tb import aedt_pkg::*; ();

    // One vertex: x in the low word, then y, then z.
    typedef logic [NUM_AXES-1:0][COORD_W-1:0] vec3_t;
    // One triangle: vertex a in the low bits, then b, then c.
    typedef logic [2:0][NUM_AXES-1:0][COORD_W-1:0] triangle_t;

    // Output word layout, lowest field last.
    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        vec3_t                off;
        vec3_t                cen;
        logic [MASK_W-1:0]    mask;
    } face_result_t;

    // The block decodes two index bits; this one maps to no register.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [COORD_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic [COORD_W-1:0] Q_ONE = 32'h0001_0000;

    localparam int PHASE_FACES = 365;
    localparam int DRAIN_CYCLES = 100;

    // ------------------------------------------------------------------------
    // Block ports; every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [COORD_W-1:0]     cfg_data      = '0;

    // Handshakes seen at the last rising edge, read by the falling-edge drivers.
    logic s_hs   = 1'b0;
    logic m_hs   = 1'b0;
    logic cfg_hs = 1'b0;

    triangle_t    tris_to_send [$];
    face_result_t face_marks_due [$];

    int faces_in   = 0;
    int faces_out  = 0;
    int mismatches = 0;

    // Sender and receiver pacing.
    int tx_gap    = 0;
    bit tx_steady = 1'b0;
    int rx_wait   = 0;
    bit rx_steady = 1'b0;
    bit rx_frozen = 1'b0;

    // Last near-axis point, reused scaled up to hit exact cosine ties.
    vec3_t last_near = '0;

    // ------------------------------------------------------------------------
    // Tracker model: its own center copy and per-direction best face.
    // ------------------------------------------------------------------------
    longint             center_q [NUM_AXES];
    logic signed [31:0] best_comp [NUM_DIR];
    logic [NORM_W-1:0]  best_norm [NUM_DIR];
    logic               dir_found [NUM_DIR];

    initial begin
        for (int k = 0; k < NUM_AXES; k++) center_q[k] = 0;
        for (int d = 0; d < NUM_DIR; d++) begin
            best_comp[d] = '0;
            best_norm[d] = '0;
            dir_found[d] = 1'b0;
        end
    end

    axis_extreme_direction_tracker dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic vec3_t xyz(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        vec3_t v;
        v[AXIS_X] = x;
        v[AXIS_Y] = y;
        v[AXIS_Z] = z;
        return v;
    endfunction

    function automatic int axis_of(int dir);
        case (dir)
            DIR_POS_X, DIR_NEG_X: return int'(AXIS_X);
            DIR_NEG_Z, DIR_POS_Z: return int'(AXIS_Z);
            default:              return int'(AXIS_Y);
        endcase
    endfunction

    function automatic bit points_negative(int dir);
        return dir == DIR_NEG_X || dir == DIR_NEG_Z || dir == DIR_NEG_Y;
    endfunction

    function automatic logic [63:0] square_mag(longint v);
        logic [63:0] m;
        m = (v < 0) ? -v : v;
        return m * m;
    endfunction

    // Append one triangle to the sender's queue.
    function automatic void send_tri(triangle_t t);
        tris_to_send.insert(tris_to_send.size(), t);
    endfunction

    // True when a/sqrt(n) beats b/sqrt(m); a zero vector ranks as cosine 0.
    function automatic bit cos_above(longint a, logic [63:0] n, longint b, logic [63:0] m);
        int           sa;
        int           sb;
        logic [127:0] lhs;
        logic [127:0] rhs;
        sa = (n == 0 || a == 0) ? 0 : ((a > 0) ? 1 : -1);
        sb = (m == 0 || b == 0) ? 0 : ((b > 0) ? 1 : -1);
        if (sa != sb) return sa > sb;
        if (sa == 0) return 1'b0;
        // compare squared cosines by cross-multiplying, magnitude flips for negatives
        lhs = 128'(square_mag(a)) * 128'(m);
        rhs = 128'(square_mag(b)) * 128'(n);
        return (sa > 0) ? (lhs > rhs) : (lhs < rhs);
    endfunction

    // Rank one triangle against the kept faces and return its output word.
    function automatic face_result_t rank_face(triangle_t t);
        face_result_t r;
        longint       s;
        longint       c;
        longint       d;
        longint       coord;
        longint       a;
        longint       b;
        longint       off [NUM_AXES];
        logic [63:0]  norm;
        bit           take;
        r    = '0;
        norm = '0;
        for (int k = 0; k < NUM_AXES; k++) begin
            s = 0;
            for (int v = 0; v < 3; v++) s += longint'($signed(t[v][k]));
            c = s / 3;  // truncates toward zero
            d = c - center_q[k];
            if (d > 64'sd2147483647) d = 64'sd2147483647;
            if (d < -64'sd2147483648) d = -64'sd2147483648;
            off[k]   = d;
            norm    += square_mag(d);
            r.cen[k] = c[31:0];
            r.off[k] = d[31:0];
        end
        for (int dir = 0; dir < NUM_DIR; dir++) begin
            coord = off[axis_of(dir)];
            a = points_negative(dir) ? -coord : coord;
            if (!dir_found[dir]) begin
                // no winner yet: anything but a face pointing straight away wins
                take = !(a < 0 && square_mag(a) == norm);
            end else begin
                b = longint'(best_comp[dir]);
                if (points_negative(dir)) b = -b;
                take = cos_above(a, norm, b, best_norm[dir]);
            end
            if (take) begin
                best_comp[dir] = coord[31:0];
                best_norm[dir] = norm;
                dir_found[dir] = 1'b1;
                r.mask[dir]    = 1'b1;
            end
        end
        return r;
    endfunction

    // Random triangle, mostly shaped to stress the ranking.
    function automatic triangle_t rand_face();
        triangle_t t;
        vec3_t     p;
        int        ax;
        t  = '0;
        p  = '0;
        ax = $urandom_range(0, NUM_AXES - 1);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                for (int v = 0; v < 3; v++)
                    for (int k = 0; k < NUM_AXES; k++) t[v][k] = $urandom;
            end
            4, 5: begin
                // near-axis point: big lead component, small jitter elsewhere
                for (int k = 0; k < NUM_AXES; k++) p[k] = $urandom_range(0, 511) - 256;
                p[ax] = $urandom_range(1 << 20, 1 << 29);
                if ($urandom_range(0, 1)) p[ax] = -p[ax];
                last_near = p;
                t = {p, p, p};
            end
            6: begin
                for (int v = 0; v < 3; v++)
                    for (int k = 0; k < NUM_AXES; k++)
                        case ($urandom_range(0, 6))
                            0: t[v][k] = Q_MAX;
                            1: t[v][k] = Q_MIN;
                            2: t[v][k] = Q_MAX - 1;
                            3: t[v][k] = Q_MIN + 1;
                            4: t[v][k] = 32'd1;
                            5: t[v][k] = 32'hFFFF_FFFF;
                            default: t[v][k] = '0;
                        endcase
            end
            7: begin
                // tiny values exercise truncation of negative sums
                for (int v = 0; v < 3; v++)
                    for (int k = 0; k < NUM_AXES; k++) t[v][k] = $urandom_range(0, 31) - 16;
            end
            8: begin
                // same direction as the last near-axis point, twice as long
                for (int k = 0; k < NUM_AXES; k++) p[k] = last_near[k] << 1;
                t = {p, p, p};
            end
            default: begin
                p[ax] = $urandom_range(1, 32'h7FFF_FFFF);
                if ($urandom_range(0, 1)) p[ax] = -p[ax];
                t = {p, p, p};
            end
        endcase
        return t;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: sample handshakes, run the model, check output words.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        face_result_t exp_r;
        face_result_t got_r;
        bit           bad;
        s_hs   <= s_axis_tvalid && s_axis_tready;
        m_hs   <= m_axis_tvalid && m_axis_tready;
        cfg_hs <= cfg_valid && cfg_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CENTER_X: center_q[AXIS_X] = longint'($signed(cfg_data));
                    CFG_CENTER_Y: center_q[AXIS_Y] = longint'($signed(cfg_data));
                    CFG_CENTER_Z: center_q[AXIS_Z] = longint'($signed(cfg_data));
                    default: ;  // spare index: drop the write
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                face_marks_due.insert(face_marks_due.size(), rank_face(s_axis_tdata));
                faces_in <= faces_in + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got_r = m_axis_tdata;
                if (face_marks_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("face %0d: output word with nothing pending: %h",
                                 faces_out, m_axis_tdata);
                end else begin
                    exp_r = face_marks_due.pop_front();
                    bad = (got_r.mask !== exp_r.mask) || (got_r.pad !== exp_r.pad);
                    for (int k = 0; k < NUM_AXES; k++)
                        bad |= (got_r.cen[k] !== exp_r.cen[k]) ||
                               (got_r.off[k] !== exp_r.off[k]);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("face %0d: mask exp %h got %h, pad exp %h got %h",
                                     faces_out, exp_r.mask, got_r.mask, exp_r.pad, got_r.pad);
                            $display("  centroid z,y,x exp %h got %h", exp_r.cen, got_r.cen);
                            $display("  offset   z,y,x exp %h got %h", exp_r.off, got_r.off);
                        end
                    end
                end
                faces_out <= faces_out + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input driver: hold a word until taken, then wait a few ready cycles
    // before the next so that gaps land right where the block opens up.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !s_hs) begin
            // hold: word not taken yet
        end else if (tx_gap > 0) begin
            if (s_axis_tready) tx_gap--;
            s_axis_tvalid <= 1'b0;
        end else if (tris_to_send.size() != 0) begin
            s_axis_tdata  <= tris_to_send.pop_front();
            s_axis_tvalid <= 1'b1;
            if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
            tx_gap = tx_steady ? 0 : $urandom_range(0, 7);
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Output receiver: after each word, stall a random number of cycles
    // counted while a word is offered; freeze entirely when asked.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (m_hs) begin
            if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
            rx_wait = rx_steady ? 0 : $urandom_range(0, 7);
        end
        if (!aresetn || rx_frozen) begin
            m_axis_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            if (m_axis_tvalid) rx_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Back-pressure burst: refuse output for a long stretch mid-run while
    // the sender keeps going, so the block backs up onto its input.
    initial begin : long_stall
        while (faces_in < 700) @(posedge aclk);
        rx_frozen = 1'b1;
        repeat (600) @(posedge aclk);
        rx_frozen = 1'b0;
    end

    // Give up if the run hangs.
    initial begin : watchdog
        #9_600_000;
        $display("[axis_extreme_direction_tracker] ERROR");
        $finish;
    end

    // Advance to a falling edge at which nothing is queued, offered or owed.
    task automatic wait_idle();
        @(negedge aclk);
        while (tris_to_send.size() != 0 || s_axis_tvalid || face_marks_due.size() != 0)
            @(negedge aclk);
    endtask

    // Leave cfg_valid high; the caller drops it after the last write.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [COORD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (!cfg_hs);
    endtask

    // Load a new center, then poke the spare index with junk.
    task automatic program_center(vec3_t c);
        write_reg(CFG_CENTER_X, c[AXIS_X]);
        write_reg(CFG_CENTER_Y, c[AXIS_Y]);
        write_reg(CFG_CENTER_Z, c[AXIS_Z]);
        write_reg(CFG_SPARE, $urandom);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        vec3_t p;
        vec3_t q;
        vec3_t c;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fresh history, center at reset value.
        // +x first: -x must refuse a face pointing straight away from it.
        p = xyz(3 * Q_ONE, 0, 0);
        send_tri({p, p, p});
        // -x now gets its first winner; +x keeps its own.
        p = xyz(-5 * Q_ONE, 0, 0);
        send_tri({p, p, p});
        // zero offset ranks as cosine 0 everywhere
        send_tri('0);
        // sums not divisible by three, negative ones included
        p = xyz(-1, -2, -4);
        q = xyz(0, 1, -1);
        send_tri({q, p, p});
        p = xyz(2, 1, 1);
        q = xyz(0, 0, 1);
        send_tri({q, p, p});
        // field extremes
        p = xyz(Q_MAX, Q_MAX, Q_MAX);
        send_tri({p, p, p});
        q = xyz(Q_MIN, Q_MIN, Q_MIN);
        send_tri({q, q, q});
        send_tri({q, p, p});
        send_tri({p, q, q});
        // equal cosines: the second one must not replace the first
        p = xyz(Q_ONE, Q_ONE, 0);
        send_tri({p, p, p});
        p = xyz(2 * Q_ONE, 2 * Q_ONE, 0);
        send_tri({p, p, p});
        // nearly parallel faces, ranked only by the low product bits
        p = xyz(32'h7FFF_0000, 1, 0);
        send_tri({p, p, p});
        p = xyz(32'h7FFF_0001, 1, 0);
        send_tri({p, p, p});
        // exact hits on the remaining axes
        p = xyz(0, 0, 4 * Q_ONE);
        send_tri({p, p, p});
        p = xyz(0, 0, -4 * Q_ONE);
        send_tri({p, p, p});
        p = xyz(0, 4 * Q_ONE, 0);
        send_tri({p, p, p});
        p = xyz(0, -4 * Q_ONE, 0);
        send_tri({p, p, p});

        // Extreme centers drive the offset into saturation.
        wait_idle();
        program_center(xyz(Q_MAX, Q_MIN, Q_MAX));
        p = xyz(Q_MIN, Q_MAX, Q_MIN);
        send_tri({p, p, p});
        p = xyz(Q_MAX, Q_MIN, Q_MAX);
        send_tri({p, p, p});
        wait_idle();
        program_center(xyz(Q_MIN, Q_MAX, Q_MIN));
        p = xyz(Q_MAX, Q_MIN, Q_MAX);
        send_tri({p, p, p});
        p = xyz(0, 0, 0);
        send_tri({p, p, p});

        // Random phases, each behind its own center setting.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: c = xyz(0, 0, 0);
                1: c = xyz($urandom, $urandom, $urandom);
                2: c = xyz(Q_MAX, Q_MIN, Q_MAX);
                3: c = xyz(Q_MIN, Q_MAX, Q_MIN);
                default: c = xyz($urandom_range(0, 32'h1_FFFF) - 32'h1_0000,
                                 $urandom_range(0, 32'h1_FFFF) - 32'h1_0000,
                                 $urandom_range(0, 32'h1_FFFF) - 32'h1_0000);
            endcase
            // the sender stays quiet until every prior result is back
            wait_idle();
            program_center(c);
            for (int n = 0; n < PHASE_FACES; n++) send_tri(rand_face());
        end

        // Drain, then allow for anything extra to show up.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && face_marks_due.size() == 0) begin
            $display("[axis_extreme_direction_tracker] OK");
        end else begin
            $display("[axis_extreme_direction_tracker] ERROR");
        end
        $finish;
    end

endmodule

### axis_extreme_direction_tracker.f
rtl/aedt_pkg.sv
rtl/aedt_div3.sv
rtl/aedt_mul.sv
rtl/axis_extreme_direction_tracker.sv
dv/axis_extreme_direction_tracker_tb.sv
